// File: design/pip_pkg.sv
// Shared constants and types for the point-in-polygon test block.
package pip_pkg;

   localparam int MAX_VERTICES = 256;
   localparam int COORD_BITS   = 32;
   localparam int ADDR_BITS    = $clog2(MAX_VERTICES);
   localparam int COUNT_BITS   = ADDR_BITS + 1;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int PROD_BITS    = 2 * DIFF_BITS;

   localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_VERTICES);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;

endpackage

// File: design/point_in_polygon_test.sv
// Top level of the point-in-polygon test: vertex store and edge-walking pipeline.
//
//   channel   direction  handshake                 payload
//   req_      in         req_valid / req_stall     operation, vertex_index, coord_x, coord_y
//   rsp_      out        rsp_valid / rsp_stall     inside_res
//   csr_      in         csr_wr_en                 vertex_count (9 bits)
//
// A load is taken while the block is idle. A query with n vertices in use reads the
// store n + 1 times, one read per cycle (the last read fetches vertex 0 again to close
// the polygon), then drains the edge pipeline and presents its result. The vertex store
// has a single read port, so the walk reads one vertex at a time. A vertex count of 0
// skips the walk and goes straight to the finish state. Reset clears control state only;
// the store holds garbage until it is loaded. A result that waits on rsp_stall holds the
// block from finishing the next query; loads are still taken while the block is idle.
module point_in_polygon_test
   import pip_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_operation,
   input  logic [ADDR_BITS-1:0]  req_vertex_index,
   input  logic signed [COORD_BITS-1:0] req_coord_x,
   input  logic signed [COORD_BITS-1:0] req_coord_y,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_inside_res,
   input  logic                  csr_wr_en,
   input  logic [COUNT_BITS-1:0] csr_wr_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   state_type state_ff;

   coord_type mem_x [MAX_VERTICES];
   coord_type mem_y [MAX_VERTICES];
   coord_type mem_x_q_ff;
   coord_type mem_y_q_ff;

   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] n_ff;
   logic [COUNT_BITS-1:0] idx_ff;
   logic [ADDR_BITS-1:0]  rd_addr;
   coord_type             px_ff;
   coord_type             py_ff;
   coord_type             prev_x_ff;
   coord_type             prev_y_ff;

   logic rd_valid_ff, rd_first_ff, rd_last_ff;
   logic e1_valid_ff, e1_last_ff, e1_skip_ff;
   logic e2_valid_ff, e2_last_ff, e2_skip_ff;
   diff_type e1_dx1_ff, e1_dy1_ff, e1_dy2_ff, e1_dx2_ff;
   prod_type e2_p1_ff, e2_p2_ff;
   logic parity_ff;
   logic parity_in;
   logic rsp_valid_ff, rsp_inside_ff;

   logic req_take, query_take, load_take;
   logic [COUNT_BITS-1:0] n_in;

   // Edge formation from the previous vertex (a) and the vertex just read (b).
   coord_type xl, yl, xh, yh;
   logic      horiz, beyond_y, left_of, on_low, skip_in;
   diff_type  dx1_in, dy1_in, dy2_in, dx2_in;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign query_take = req_take && (op_type'(req_operation) == OP_QUERY);
   assign load_take  = req_take && (op_type'(req_operation) == OP_LOAD);
   assign n_in       = (count_ff > MAX_COUNT) ? MAX_COUNT : count_ff;
   assign rd_addr    = (idx_ff == n_ff) ? '0 : idx_ff[ADDR_BITS-1:0];

   always_comb begin
      horiz    = (prev_y_ff == mem_y_q_ff);
      beyond_y = (py_ff < prev_y_ff && py_ff < mem_y_q_ff) ||
                 (py_ff > prev_y_ff && py_ff > mem_y_q_ff);
      left_of  = (px_ff < prev_x_ff) && (px_ff < mem_x_q_ff);
      if (prev_y_ff < mem_y_q_ff) begin
         xl = prev_x_ff;  yl = prev_y_ff;  xh = mem_x_q_ff;  yh = mem_y_q_ff;
      end else begin
         xl = mem_x_q_ff; yl = mem_y_q_ff; xh = prev_x_ff;   yh = prev_y_ff;
      end
      // A point level with the lower end never counts; the upper end owns that vertex.
      on_low  = (py_ff == yl);
      skip_in = horiz || beyond_y || left_of || on_low;
      dx1_in  = DIFF_BITS'(px_ff) - DIFF_BITS'(xl);
      dy1_in  = DIFF_BITS'(yh) - DIFF_BITS'(yl);
      dy2_in  = DIFF_BITS'(py_ff) - DIFF_BITS'(yl);
      dx2_in  = DIFF_BITS'(xh) - DIFF_BITS'(xl);
   end

   assign parity_in = parity_ff ^ (e2_valid_ff && !e2_skip_ff && (e2_p1_ff >= e2_p2_ff));

   // Vertex store: written by loads while idle, read once per cycle during a walk.
   always_ff @(posedge clock) begin
      if (load_take) begin
         mem_x[req_vertex_index] <= req_coord_x;
         mem_y[req_vertex_index] <= req_coord_y;
      end
      mem_x_q_ff <= mem_x[rd_addr];
      mem_y_q_ff <= mem_y[rd_addr];
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      if (query_take) begin
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
         n_ff  <= n_in;
      end
      if (rd_valid_ff) begin
         prev_x_ff <= mem_x_q_ff;
         prev_y_ff <= mem_y_q_ff;
      end
      e1_skip_ff <= skip_in;
      e1_dx1_ff  <= dx1_in;
      e1_dy1_ff  <= dy1_in;
      e1_dy2_ff  <= dy2_in;
      e1_dx2_ff  <= dx2_in;
      e2_skip_ff <= e1_skip_ff;
      e2_p1_ff   <= PROD_BITS'(e1_dx1_ff) * PROD_BITS'(e1_dy1_ff);
      e2_p2_ff   <= PROD_BITS'(e1_dy2_ff) * PROD_BITS'(e1_dx2_ff);
      e1_last_ff <= rd_last_ff;
      e2_last_ff <= e1_last_ff;
   end

   // Control: state, read tags, stage valids, parity and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rd_first_ff   <= 1'b0;
         rd_last_ff    <= 1'b0;
         e1_valid_ff   <= 1'b0;
         e2_valid_ff   <= 1'b0;
         parity_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         rsp_inside_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_valid_ff <= 1'b0;
         rd_first_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
         e1_valid_ff <= rd_valid_ff && !rd_first_ff;
         e2_valid_ff <= e1_valid_ff;
         parity_ff   <= parity_in;
         case (state_ff)
            ST_IDLE: begin
               if (query_take) begin
                  idx_ff    <= '0;
                  parity_ff <= 1'b0;
                  state_ff  <= (n_in == '0) ? ST_FINISH : ST_ISSUE;
               end
            end
            ST_ISSUE: begin
               rd_valid_ff <= 1'b1;
               rd_first_ff <= (idx_ff == '0);
               rd_last_ff  <= (idx_ff == n_ff);
               idx_ff      <= idx_ff + 1'b1;
               if (idx_ff == n_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (e2_valid_ff && e2_last_ff) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_inside_ff <= parity_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule

// File: design/pip_checker.sv
// Port-level checker for the point-in-polygon test, bound to the top level.
module pip_checker
   import pip_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  req_operation,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_inside_res
);

   // A result that is held back keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_inside_res))
      else $error("held result changed");

   // A query occupies the block for at least the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (op_type'(req_operation) == OP_QUERY) |=> req_stall)
      else $error("query did not block the request side");

   // A load leaves the block ready for the next request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (op_type'(req_operation) == OP_LOAD) |=> !req_stall)
      else $error("load left the request side stalled");

   // A new result only appears at the end of a query, while requests are held off.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a query in progress");

endmodule

bind point_in_polygon_test pip_checker u_pip_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_operation  (req_operation),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_inside_res (rsp_inside_res)
);

// File: tb/sv/tb_point_in_polygon_test.sv
// Self-checking testbench for the point-in-polygon test block, with a ray-casting predictor.
module tb_point_in_polygon_test;
   timeunit 1ns;
   timeprecision 1ps;

   import pip_pkg::*;

   localparam int ITEM_TARGET = 1750;
   localparam int IDLE_LIMIT  = 4000;
   localparam int SETTLE      = MAX_VERTICES + 8;

   localparam coord_type COORD_MIN = 32'sh8000_0000;
   localparam coord_type COORD_MAX = 32'sh7fff_ffff;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_operation = 1'b0;
   logic [ADDR_BITS-1:0]  req_vertex_index = '0;
   coord_type             req_coord_x = '0;
   coord_type             req_coord_y = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_inside_res;
   logic                  csr_wr_en = 1'b0;
   logic [COUNT_BITS-1:0] csr_wr_data = '0;

   // Shadow copy of the vertex store and the vertex count register.
   coord_type             shadow_x [MAX_VERTICES];
   coord_type             shadow_y [MAX_VERTICES];
   logic [COUNT_BITS-1:0] shadow_count = '0;

   bit expected_inside [$];
   bit want;
   bit steady = 1'b0;
   int errors = 0;
   int items_accepted = 0;
   int loads_accepted = 0;
   int queries_accepted = 0;
   int results_checked = 0;
   int inside_answers = 0;
   int count_writes = 0;
   int idle_cycles = 0;

   point_in_polygon_test uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_vertex_index (req_vertex_index),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_inside_res   (rsp_inside_res),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // One edge of the closed polygon against a ray from the point toward -x.
   function automatic bit edge_crosses_ray(longint px, longint py, longint ax, longint ay,
                                           longint bx, longint by);
      longint lx, ly, hx, hy;
      logic signed [69:0] dpx, dpy, dhx, dhy;
      if (ay == by) return 1'b0;
      if ((py < ay && py < by) || (py > ay && py > by)) return 1'b0;
      if (px < ax && px < bx) return 1'b0;
      if (ay < by) begin
         lx = ax; ly = ay; hx = bx; hy = by;
      end else begin
         lx = bx; ly = by; hx = ax; hy = ay;
      end
      dpx = 70'(px - lx);
      dpy = 70'(py - ly);
      dhx = 70'(hx - lx);
      dhy = 70'(hy - ly);
      // Exact cross-multiplication; the 66-bit products fit without rounding.
      if (dpx * dhy < dpy * dhx) return 1'b0;
      // A point level with the lower end only counts at the upper end of an edge.
      if (py == ly) return 1'b0;
      return 1'b1;
   endfunction

   function automatic bit predict_inside(coord_type px, coord_type py);
      int unsigned n, j;
      bit parity;
      n = (shadow_count > MAX_COUNT) ? MAX_VERTICES : shadow_count;
      parity = 1'b0;
      for (int unsigned i = 0; i < n; i++) begin
         j = (i + 1 == n) ? 0 : i + 1;
         parity ^= edge_crosses_ray(px, py, shadow_x[i], shadow_y[i], shadow_x[j], shadow_y[j]);
      end
      return parity;
   endfunction

   function automatic coord_type phase_coord(bit full_range, int span, int scale);
      if (full_range) return coord_type'($urandom);
      return coord_type'((int'($urandom_range(0, 2 * span)) - span) * scale);
   endfunction

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 32);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_inside.size() == 0) begin
            $error("inside_res: no transaction expected, actual %0b", rsp_inside_res);
            errors++;
         end else begin
            want = expected_inside.pop_front();
            if (rsp_inside_res !== want) begin
               $error("inside_res mismatch: expected %0b, actual %0b", want, rsp_inside_res);
               errors++;
            end
            results_checked++;
            inside_answers += want;
         end
      end
   end

   // Ends the run if nothing moves on any port for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(op_type op, logic [ADDR_BITS-1:0] slot, coord_type x, coord_type y);
      while (!steady && $urandom_range(0, 99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_vertex_index <= slot;
      req_coord_x      <= x;
      req_coord_y      <= y;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_accepted++;
      if (op == OP_LOAD) begin
         shadow_x[slot] = x;
         shadow_y[slot] = y;
         loads_accepted++;
      end else begin
         expected_inside.push_back(predict_inside(x, y));
         queries_accepted++;
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_inside.size() != 0) @(posedge clock);
   endtask

   // Loads give no result, so the block gets time to settle before the register changes.
   task automatic write_vertex_count(logic [COUNT_BITS-1:0] value);
      drain_results();
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      shadow_count = value;
      count_writes++;
   endtask

   task automatic test_empty_polygon();
      send_item(OP_QUERY, '0, '0, '0);
      write_vertex_count('0);
      send_item(OP_QUERY, '1, COORD_MAX, COORD_MAX);
   endtask

   task automatic test_extreme_triangle();
      send_item(OP_LOAD, 8'd0, COORD_MIN, COORD_MIN);
      send_item(OP_LOAD, 8'd1, COORD_MAX, COORD_MIN);
      send_item(OP_LOAD, 8'd2, COORD_MAX, COORD_MAX);
      send_item(OP_LOAD, 8'd255, COORD_MAX, '0);
      write_vertex_count(COUNT_BITS'(3));
      send_item(OP_QUERY, '0, '0, '0);
      send_item(OP_QUERY, '0, 32'sd1, '0);
      send_item(OP_QUERY, '0, '0, 32'sd1);
      send_item(OP_QUERY, '0, COORD_MIN, COORD_MAX);
      send_item(OP_QUERY, '0, COORD_MAX, COORD_MIN);
      send_item(OP_QUERY, '0, COORD_MAX, '0);
      send_item(OP_QUERY, '0, COORD_MIN, COORD_MIN);
   endtask

   task automatic test_single_vertex();
      write_vertex_count(COUNT_BITS'(1));
      send_item(OP_QUERY, '0, COORD_MIN, COORD_MIN);
      send_item(OP_QUERY, '0, '0, '0);
   endtask

   // Fills every slot with a square of 64 vertices per side, then uses the full store.
   task automatic test_full_store_and_capacity();
      int half, step;
      logic [COUNT_BITS-1:0] counts [4];
      half = 64 <<< 16;
      step = (2 * half) / 64;
      counts = '{COUNT_BITS'(MAX_VERTICES), COUNT_BITS'(511), COUNT_BITS'(300),
                 COUNT_BITS'(MAX_VERTICES + 1)};
      for (int i = 0; i < 64; i++) begin
         send_item(OP_LOAD, ADDR_BITS'(i), coord_type'(-half + i * step), coord_type'(-half));
         send_item(OP_LOAD, ADDR_BITS'(64 + i), coord_type'(half), coord_type'(-half + i * step));
         send_item(OP_LOAD, ADDR_BITS'(128 + i), coord_type'(half - i * step), coord_type'(half));
         send_item(OP_LOAD, ADDR_BITS'(192 + i), coord_type'(-half), coord_type'(half - i * step));
      end
      foreach (counts[c]) begin
         write_vertex_count(counts[c]);
         send_item(OP_QUERY, '0, '0, '0);
         send_item(OP_QUERY, '0, coord_type'(-half), '0);
         send_item(OP_QUERY, '0, coord_type'(half + 1), '0);
         send_item(OP_QUERY, '0, shadow_x[100], shadow_y[100]);
      end
   endtask

   task automatic run_polygon_phase();
      int pick, span, scale, n, used, nq, k;
      bit full_range;
      coord_type qx, qy;
      pick = $urandom_range(0, 99);
      if (pick < 4) n = 0;
      else if (pick < 8) n = 1;
      else if (pick < 12) n = 2;
      else if (pick < 88) n = $urandom_range(3, 12);
      else if (pick < 96) n = $urandom_range(13, 40);
      else n = $urandom_range(0, 1) ? $urandom_range(MAX_VERTICES, 511) : MAX_VERTICES;
      used = (n > MAX_VERTICES) ? MAX_VERTICES : n;
      span = $urandom_range(0, 1) ? $urandom_range(2, 6) : $urandom_range(7, 100);
      scale = 1 << (8 * $urandom_range(0, 3));
      full_range = ($urandom_range(0, 99) < 15);
      write_vertex_count(COUNT_BITS'(n));
      if (used <= 40) begin
         for (int i = 0; i < used; i++)
            send_item(OP_LOAD, ADDR_BITS'(i), phase_coord(full_range, span, scale),
                      phase_coord(full_range, span, scale));
      end else begin
         repeat (4) send_item(OP_LOAD, ADDR_BITS'($urandom), phase_coord(full_range, span, scale),
                              phase_coord(full_range, span, scale));
      end
      nq = (used > 40) ? 4 : $urandom_range(6, 30);
      repeat (nq) begin
         pick = $urandom_range(0, 99);
         k = (used > 0) ? $urandom_range(0, used - 1) : 0;
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               qx = phase_coord(full_range, span, scale);
               qy = phase_coord(full_range, span, scale);
            end
            4, 5: begin
               qx = phase_coord(full_range, span, scale);
               qy = shadow_y[k];
            end
            6: begin
               qx = shadow_x[k];
               qy = shadow_y[k];
            end
            7: begin
               qx = coord_type'($urandom);
               qy = coord_type'($urandom);
            end
            default: begin
               qx = shadow_x[k] + int'($urandom_range(0, 2)) - 1;
               qy = phase_coord(full_range, span, scale);
            end
         endcase
         if (pick < 10) begin
            send_item(OP_LOAD, ADDR_BITS'($urandom), qx, qy);
         end else if (pick < 13) begin
            // Hold off the sender until every outstanding answer is back.
            drain_results();
         end else begin
            send_item(OP_QUERY, ADDR_BITS'($urandom), qx, qy);
         end
      end
   endtask

   task automatic test_random_polygons(int target);
      while (items_accepted < target) run_polygon_phase();
   endtask

   task automatic test_back_to_back();
      steady = 1'b1;
      repeat (6) run_polygon_phase();
      steady = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_polygon();
      test_extreme_triangle();
      test_single_vertex();
      test_full_store_and_capacity();
      test_random_polygons(ITEM_TARGET / 2);
      test_back_to_back();
      test_random_polygons(ITEM_TARGET);
      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (expected_inside.size() != 0) begin
         $error("inside_res: %0d expected transactions never arrived", expected_inside.size());
         errors++;
      end
      $display("Ran %0d vertex loads and %0d point queries (%0d inside) over %0d count settings.",
               loads_accepted, queries_accepted, inside_answers, count_writes);
      $display("Polygons ranged from empty and single-vertex to full and above capacity.");
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
